// ----- hw/rtl/lrrsa_pkg.sv -----
// ----------------------------------------------------------------------------
// lrrsa_pkg
// Shared codes, field widths and the controller-to-datapath command bundle
// for the locking round-robin switch allocator.
// ----------------------------------------------------------------------------
package lrrsa_pkg;

    localparam int ACTION_W  = 2;
    localparam int PORT_W    = 3;
    localparam int CHANNEL_W = 2;
    localparam int COUNT_W   = 5;

    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GRANT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic load_in;   // capture the incoming transaction
        logic exec;      // apply the held item and load the result register
    } cmd_t;

endpackage

// ----- hw/rtl/lrrsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrrsa_ctrl
// Sequencer: takes one transaction, runs it through the datapath once the
// result register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lrrsa_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output lrrsa_pkg::cmd_t cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign cmd.load_in = s_tvalid && s_tready;
    assign cmd.exec    = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (s_tvalid)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (cmd.exec)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction is always followed by an execute cycle
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not scheduled");

    // executing always presents a result next cycle
    a_exec_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("result not presented after execute");

    // a stalled result blocks the next execute
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && state_reg == ST_EXEC) |=> (state_reg == ST_EXEC))
        else $error("result overwritten while stalled");

endmodule

// ----- hw/rtl/lrrsa_datapath.sv -----
// ----------------------------------------------------------------------------
// lrrsa_datapath
// Per-output request vectors, lock and winner state, round-robin picker,
// pending counters and the result register.
// ----------------------------------------------------------------------------
module lrrsa_datapath
#(
    parameter int NUM_PORTS    = 5,
    parameter int NUM_CHANNELS = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  lrrsa_pkg::cmd_t                     cmd,
    input  logic [lrrsa_pkg::ACTION_W-1:0]      action,
    input  logic [lrrsa_pkg::PORT_W-1:0]        out_port,
    input  logic [lrrsa_pkg::PORT_W-1:0]        in_port,
    input  logic [lrrsa_pkg::CHANNEL_W-1:0]     in_channel,
    output logic                                grant_valid,
    output logic [lrrsa_pkg::PORT_W-1:0]        grant_port,
    output logic [lrrsa_pkg::CHANNEL_W-1:0]     grant_channel,
    output logic                                no_request_error,
    output logic [lrrsa_pkg::COUNT_W-1:0]       pending_count,
    output logic                                all_idle
);

    localparam int PAIRS = NUM_PORTS * NUM_CHANNELS;
    localparam int BI_W  = $clog2(PAIRS);
    localparam int OP_W  = $clog2(NUM_PORTS);

    typedef struct packed {
        logic                               found;
        logic [BI_W-1:0]                    idx;
        logic [lrrsa_pkg::PORT_W-1:0]       port;
        logic [lrrsa_pkg::CHANNEL_W-1:0]    chan;
    } pick_t;

    // lowest raised bit; pair index p*NUM_CHANNELS+c maps back to (p, c)
    function automatic pick_t first_set(input logic [PAIRS-1:0] v);
        pick_t r;
        r = '0;
        for (int p = NUM_PORTS - 1; p >= 0; p--)
        begin
            for (int c = NUM_CHANNELS - 1; c >= 0; c--)
            begin
                if (v[p * NUM_CHANNELS + c])
                begin
                    r.found = 1'b1;
                    r.idx   = BI_W'(p * NUM_CHANNELS + c);
                    r.port  = lrrsa_pkg::PORT_W'(p);
                    r.chan  = lrrsa_pkg::CHANNEL_W'(c);
                end
            end
        end
        return r;
    endfunction

    // held transaction
    logic [lrrsa_pkg::ACTION_W-1:0]     act_reg;
    logic [lrrsa_pkg::PORT_W-1:0]       op_reg;
    logic [lrrsa_pkg::PORT_W-1:0]       ip_reg;
    logic [lrrsa_pkg::CHANNEL_W-1:0]    ich_reg;

    // per-output state
    logic [PAIRS-1:0]                   request_reg  [NUM_PORTS];
    logic [PAIRS-1:0]                   request_next [NUM_PORTS];
    logic                               locked_reg   [NUM_PORTS];
    logic                               locked_next  [NUM_PORTS];
    logic                               held_reg     [NUM_PORTS];
    logic                               held_next    [NUM_PORTS];
    logic [BI_W-1:0]                    last_reg     [NUM_PORTS];
    logic [BI_W-1:0]                    last_next    [NUM_PORTS];
    logic [lrrsa_pkg::PORT_W-1:0]       wport_reg    [NUM_PORTS];
    logic [lrrsa_pkg::PORT_W-1:0]       wport_next   [NUM_PORTS];
    logic [lrrsa_pkg::CHANNEL_W-1:0]    wchan_reg    [NUM_PORTS];
    logic [lrrsa_pkg::CHANNEL_W-1:0]    wchan_next   [NUM_PORTS];
    logic [lrrsa_pkg::COUNT_W-1:0]      cnt_reg      [NUM_PORTS];
    logic [lrrsa_pkg::COUNT_W-1:0]      cnt_next     [NUM_PORTS];

    // result register
    logic                               gv_reg;
    logic [lrrsa_pkg::PORT_W-1:0]       gp_reg;
    logic [lrrsa_pkg::CHANNEL_W-1:0]    gc_reg;
    logic                               err_reg;
    logic [lrrsa_pkg::COUNT_W-1:0]      pend_reg;
    logic                               idle_reg;

    logic                               gv_next;
    logic [lrrsa_pkg::PORT_W-1:0]       gp_next;
    logic [lrrsa_pkg::CHANNEL_W-1:0]    gc_next;
    logic                               err_next;
    logic [lrrsa_pkg::COUNT_W-1:0]      pend_next;
    logic                               idle_next;

    logic                               op_ok;
    logic [OP_W-1:0]                    op_idx;
    logic [PAIRS-1:0]                   sel_mask;
    logic [PAIRS-1:0]                   row;
    logic [PAIRS-1:0]                   search_mask;
    logic [PAIRS-1:0]                   hi;
    logic                               hit;
    pick_t                              pick;

    assign op_ok  = ({1'b0, op_reg} < 4'(NUM_PORTS));
    assign op_idx = op_ok ? op_reg[OP_W-1:0] : '0;
    assign row    = op_ok ? request_reg[op_idx] : '0;
    assign hit    = |(row & sel_mask);
    assign hi     = row & search_mask;
    assign pick   = (|hi) ? first_set(hi) : first_set(row);

    // one-hot of the addressed pair; an out-of-range pair selects nothing
    always_comb
    begin
        sel_mask = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                sel_mask[p * NUM_CHANNELS + c] =
                    ({1'b0, ip_reg} == 4'(p)) && ({2'b0, ich_reg} == 4'(c));
            end
        end
    end

    // round robin: first search strictly above the last winner, then wrap
    always_comb
    begin
        for (int i = 0; i < PAIRS; i++)
        begin
            search_mask[i] = !held_reg[op_idx] || (BI_W'(i) > last_reg[op_idx]);
        end
    end

    always_comb
    begin
        request_next = request_reg;
        locked_next  = locked_reg;
        held_next    = held_reg;
        last_next    = last_reg;
        wport_next   = wport_reg;
        wchan_next   = wchan_reg;
        cnt_next     = cnt_reg;
        gv_next      = 1'b0;
        gp_next      = '0;
        gc_next      = '0;
        err_next     = 1'b0;
        pend_next    = '0;
        idle_next    = 1'b1;

        if (cmd.exec && op_ok)
        begin
            case (act_reg)
                lrrsa_pkg::ACT_SET:
                begin
                    request_next[op_idx] = row | sel_mask;
                    if (!hit && (|sel_mask))
                    begin
                        cnt_next[op_idx] = cnt_reg[op_idx] + 5'd1;
                    end
                end
                lrrsa_pkg::ACT_GRANT:
                begin
                    if (locked_reg[op_idx])
                    begin
                        gv_next = 1'b1;
                        gp_next = wport_reg[op_idx];
                        gc_next = wchan_reg[op_idx];
                    end
                    else if (pick.found)
                    begin
                        locked_next[op_idx] = 1'b1;
                        held_next[op_idx]   = 1'b1;
                        last_next[op_idx]   = pick.idx;
                        wport_next[op_idx]  = pick.port;
                        wchan_next[op_idx]  = pick.chan;
                        gv_next             = 1'b1;
                        gp_next             = pick.port;
                        gc_next             = pick.chan;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                lrrsa_pkg::ACT_CLEAR:
                begin
                    locked_next[op_idx]  = 1'b0;
                    request_next[op_idx] = row & ~sel_mask;
                    if (hit)
                    begin
                        cnt_next[op_idx] = cnt_reg[op_idx] - 5'd1;
                    end
                end
                default:
                begin
                end
            endcase
            pend_next = cnt_next[op_idx];
        end

        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (|request_next[p])
            begin
                idle_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                request_reg[p] <= '0;
                locked_reg[p]  <= 1'b0;
                held_reg[p]    <= 1'b0;
                last_reg[p]    <= '0;
                wport_reg[p]   <= '0;
                wchan_reg[p]   <= '0;
                cnt_reg[p]     <= '0;
            end
        end
        else
        begin
            request_reg <= request_next;
            locked_reg  <= locked_next;
            held_reg    <= held_next;
            last_reg    <= last_next;
            wport_reg   <= wport_next;
            wchan_reg   <= wchan_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            act_reg <= action;
            op_reg  <= out_port;
            ip_reg  <= in_port;
            ich_reg <= in_channel;
        end
        if (cmd.exec)
        begin
            gv_reg   <= gv_next;
            gp_reg   <= gp_next;
            gc_reg   <= gc_next;
            err_reg  <= err_next;
            pend_reg <= pend_next;
            idle_reg <= idle_next;
        end
    end

    assign grant_valid      = gv_reg;
    assign grant_port       = gp_reg;
    assign grant_channel    = gc_reg;
    assign no_request_error = err_reg;
    assign pending_count    = pend_reg;
    assign all_idle         = idle_reg;

endmodule

// ----- hw/rtl/locking_round_robin_switch_allocator_core.sv -----
// ----------------------------------------------------------------------------
// locking_round_robin_switch_allocator_core
// Round-robin switch allocator with one locking arbiter per output port.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one command per transaction: s_tuser selects set,
//   grant or clear; s_tdata names the output port and the input port /
//   virtual channel pair. Every command yields exactly one result on the
//   master channel: grant, no-request flag, requests pending at the
//   addressed output and a global idle flag.
//   A grant on an unlocked output picks the next raised pair after the
//   previous winner and locks the output; later grants repeat that winner
//   until any clear on the output unlocks it.
//   The accepted command is held in the input register, and the update/pick
//   stage then loads the result register once it is free. No transaction
//   is taken while one is held: the two-state sequencer loads the input
//   register in the idle state and runs the update/pick stage in execute.
//   A stalled result (m_tready low) holds in the output register; one more
//   transaction is accepted and waits until the result is taken.
//   Reset clears all requests, locks and round-robin pointers at once.
// ----------------------------------------------------------------------------
module locking_round_robin_switch_allocator_core
#(
    parameter int NUM_PORTS    = 5,
    parameter int NUM_CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // out_port[2:0], in_port[5:3], in_channel[7:6]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // grant_valid[0], grant_port[3:1], grant_channel[5:4],
                                   // no_request_error[6], pending_count[11:7],
                                   // all_idle[12], zero[15:13]
);

    lrrsa_pkg::cmd_t                     cmd;
    logic                                grant_valid;
    logic [lrrsa_pkg::PORT_W-1:0]        grant_port;
    logic [lrrsa_pkg::CHANNEL_W-1:0]     grant_channel;
    logic                                no_request_error;
    logic [lrrsa_pkg::COUNT_W-1:0]       pending_count;
    logic                                all_idle;

    lrrsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lrrsa_datapath
    #(
        .NUM_PORTS    (NUM_PORTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .action           (s_tuser),
        .out_port         (s_tdata[2:0]),
        .in_port          (s_tdata[5:3]),
        .in_channel       (s_tdata[7:6]),
        .grant_valid      (grant_valid),
        .grant_port       (grant_port),
        .grant_channel    (grant_channel),
        .no_request_error (no_request_error),
        .pending_count    (pending_count),
        .all_idle         (all_idle)
    );

    assign m_tdata = {3'b000, all_idle, pending_count, no_request_error,
                      grant_channel, grant_port, grant_valid};

endmodule

// ----- test/alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_checker
// Watches both stream channels of the switch allocator. Each accepted command
// runs through a local copy of the per-output request vectors, locks and
// round-robin pointers. The predicted result is queued and compared field by
// field against the next result taken on the master channel.
// ----------------------------------------------------------------------------
module alloc_checker
#(
    parameter int NUM_PORTS    = 5,
    parameter int NUM_CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // out_port[2:0], in_port[5:3], in_channel[7:6]
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // grant_valid[0], grant_port[3:1], grant_channel[5:4],
                                   // no_request_error[6], pending_count[11:7], all_idle[12]
    output int          fail_count,
    output int          outstanding
);

    localparam int PAIRS = NUM_PORTS * NUM_CHANNELS;
    localparam int BI_W  = $clog2(PAIRS);

    typedef struct packed {
        logic                            grant_valid;
        logic [lrrsa_pkg::PORT_W-1:0]    grant_port;
        logic [lrrsa_pkg::CHANNEL_W-1:0] grant_channel;
        logic                            no_request_error;
        logic [lrrsa_pkg::COUNT_W-1:0]   pending_count;
        logic                            all_idle;
    } alloc_result_t;

    logic [PAIRS-1:0] req_vec   [NUM_PORTS];
    logic             locked    [NUM_PORTS];
    logic [BI_W-1:0]  last_win  [NUM_PORTS];
    logic             win_valid [NUM_PORTS];

    alloc_result_t    expected_results [$];

    function automatic alloc_result_t arbitrate(logic [lrrsa_pkg::ACTION_W-1:0]  act,
                                                logic [lrrsa_pkg::PORT_W-1:0]    op,
                                                logic [lrrsa_pkg::PORT_W-1:0]    ip,
                                                logic [lrrsa_pkg::CHANNEL_W-1:0] ich);
        alloc_result_t r;
        logic          pair_ok;
        int            pair_idx;
        int            first;
        int            found;
        int            idx;
        r = '0;
        if (op < NUM_PORTS)
        begin
            pair_ok  = (ip < NUM_PORTS) && (ich < NUM_CHANNELS);
            pair_idx = pair_ok ? ip * NUM_CHANNELS + ich : 0;
            case (act)
                lrrsa_pkg::ACT_SET:
                begin
                    if (pair_ok)
                        req_vec[op][pair_idx] = 1'b1;
                end
                lrrsa_pkg::ACT_GRANT:
                begin
                    if (locked[op])
                        r.grant_valid = 1'b1;
                    else
                    begin
                        // search starts just past the previous winner
                        first = win_valid[op] ? int'(last_win[op]) + 1 : 0;
                        found = -1;
                        for (int k = 0; k < PAIRS && found < 0; k++)
                        begin
                            idx = (first + k) % PAIRS;
                            if (req_vec[op][idx])
                                found = idx;
                        end
                        if (found >= 0)
                        begin
                            last_win[op]  = BI_W'(found);
                            win_valid[op] = 1'b1;
                            locked[op]    = 1'b1;
                            r.grant_valid = 1'b1;
                        end
                        else
                            r.no_request_error = 1'b1;
                    end
                    if (r.grant_valid)
                    begin
                        r.grant_port    = lrrsa_pkg::PORT_W'(int'(last_win[op]) / NUM_CHANNELS);
                        r.grant_channel =
                            lrrsa_pkg::CHANNEL_W'(int'(last_win[op]) % NUM_CHANNELS);
                    end
                end
                lrrsa_pkg::ACT_CLEAR:
                begin
                    locked[op] = 1'b0;
                    if (pair_ok)
                        req_vec[op][pair_idx] = 1'b0;
                end
                default: ;
            endcase
            r.pending_count = lrrsa_pkg::COUNT_W'($countones(req_vec[op]));
        end
        r.all_idle = 1'b1;
        for (int p = 0; p < NUM_PORTS; p++)
            if (req_vec[p] != '0)
                r.all_idle = 1'b0;
        return r;
    endfunction

    task automatic report(string field, int exp_val, int got_val);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, field, exp_val,
                     got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t exp_r;
        alloc_result_t got_r;
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                req_vec[p]   = '0;
                locked[p]    = 1'b0;
                last_win[p]  = '0;
                win_valid[p] = 1'b0;
            end
            expected_results.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_r = {m_tdata[0], m_tdata[3:1], m_tdata[5:4], m_tdata[6], m_tdata[11:7],
                         m_tdata[12]};
                if (expected_results.size() == 0)
                    report("unexpected result transaction, m_tdata", 0, int'(m_tdata));
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.grant_valid !== exp_r.grant_valid)
                        report("grant_valid", int'(exp_r.grant_valid),
                               int'(got_r.grant_valid));
                    if (got_r.grant_port !== exp_r.grant_port)
                        report("grant_port", int'(exp_r.grant_port), int'(got_r.grant_port));
                    if (got_r.grant_channel !== exp_r.grant_channel)
                        report("grant_channel", int'(exp_r.grant_channel),
                               int'(got_r.grant_channel));
                    if (got_r.no_request_error !== exp_r.no_request_error)
                        report("no_request_error", int'(exp_r.no_request_error),
                               int'(got_r.no_request_error));
                    if (got_r.pending_count !== exp_r.pending_count)
                        report("pending_count", int'(exp_r.pending_count),
                               int'(got_r.pending_count));
                    if (got_r.all_idle !== exp_r.all_idle)
                        report("all_idle", int'(exp_r.all_idle), int'(got_r.all_idle));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(arbitrate(s_tuser, s_tdata[2:0], s_tdata[5:3],
                                                     s_tdata[7:6]));
            outstanding = expected_results.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the locking round-robin switch allocator. A short
// directed run covers grant errors, locking, round-robin wrap and every
// out-of-range case; a random run then alternates fill, drain and full-clear
// sweeps with bursty idling on both channels and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int NUM_PORTS    = 5;
    localparam int NUM_CHANNELS = 4;
    localparam int PAIRS        = NUM_PORTS * NUM_CHANNELS;
    localparam int RAND_ITEMS   = 1600;
    localparam int QUIET_TAIL   = 200;
    localparam int STALL_AT     = 300;
    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [lrrsa_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // out_port[2:0], in_port[5:3], in_channel[7:6]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // grant_valid[0], grant_port[3:1], grant_channel[5:4],
                            // no_request_error[6], pending_count[11:7], all_idle[12]
    int          fail_count;
    int          outstanding;

    int          sent;
    int          gap_rate;
    int          cycles = 0;
    logic        quiet;
    logic        stall_req;

    always #10 clk = ~clk;

    locking_round_robin_switch_allocator_core #(
        .NUM_PORTS    (NUM_PORTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alloc_checker #(
        .NUM_PORTS    (NUM_PORTS),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random ready bursts, one long hold-off, always ready at the end
    initial
    begin
        int hold_left;
        int gap_left;
        int run_left;
        logic hold_done;
        hold_left = 0;
        gap_left  = 0;
        run_left  = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                m_tready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = STALL_CYCLES;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                m_tready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                m_tready <= 1'b1;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                gap_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                run_left = $urandom_range(0, 40);
                m_tready <= 1'b1;
            end
        end
    end

    // one command transaction, then possibly an idle burst
    task automatic send_cmd(logic [lrrsa_pkg::ACTION_W-1:0]  act,
                            logic [lrrsa_pkg::PORT_W-1:0]    op,
                            logic [lrrsa_pkg::PORT_W-1:0]    ip,
                            logic [lrrsa_pkg::CHANNEL_W-1:0] ich);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {ich, ip, op};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
        if (!quiet && gap_rate > 0 && $urandom_range(0, 7) < gap_rate * 2)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    initial
    begin
        int                              r;
        logic                            fill;
        logic [lrrsa_pkg::ACTION_W-1:0]  act;
        logic [lrrsa_pkg::PORT_W-1:0]    op;
        logic [lrrsa_pkg::PORT_W-1:0]    ip;
        logic [lrrsa_pkg::CHANNEL_W-1:0] ich;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = lrrsa_pkg::ACT_SET;
        sent      = 0;
        gap_rate  = 0;
        quiet     = 1'b0;
        stall_req = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: locking, round-robin wrap, error and out-of-range cases
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);   // first grant, nothing requested
        send_cmd(lrrsa_pkg::ACT_SET,   3'd0, 3'd0, 2'd0);
        send_cmd(lrrsa_pkg::ACT_SET,   3'd0, 3'd4, 2'd3);
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);   // search from index 0
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);   // locked, same winner
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd0, 3'd2, 2'd1);   // clear of a pair not held unlocks
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd0, 3'd4, 2'd3);
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);   // wraps past the top pair
        send_cmd(lrrsa_pkg::ACT_SET,   3'd4, 3'd7, 2'd3);   // pair out of range
        send_cmd(lrrsa_pkg::ACT_SET,   3'd7, 3'd4, 2'd2);   // output out of range
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd5, 3'd0, 2'd0);
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd6, 3'd0, 2'd0);
        send_cmd(ACT_SPARE,            3'd0, 3'd1, 2'd1);
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd0, 3'd7, 2'd0);   // unlock only
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd0, 3'd0, 2'd0);   // everything idle again
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd0, 3'd0, 2'd0);   // error with a winner on record
        send_cmd(lrrsa_pkg::ACT_SET,   3'd4, 3'd4, 2'd3);
        send_cmd(lrrsa_pkg::ACT_GRANT, 3'd4, 3'd0, 2'd0);
        send_cmd(lrrsa_pkg::ACT_CLEAR, 3'd4, 3'd4, 2'd3);
        send_cmd(ACT_SPARE,            3'd7, 3'd7, 2'd3);

        // random: blocks of fill / drain traffic, with periodic full-clear sweeps
        for (int blk = 0; sent < RAND_ITEMS; blk++)
        begin
            gap_rate = $urandom_range(0, 2);
            fill     = (blk % 2 == 0);
            if (blk % 6 == 5)
            begin
                for (int p = 0; p < NUM_PORTS; p++)
                    for (int k = 0; k < PAIRS; k++)
                    begin
                        send_cmd(lrrsa_pkg::ACT_CLEAR, lrrsa_pkg::PORT_W'(p),
                                 lrrsa_pkg::PORT_W'(k / NUM_CHANNELS),
                                 lrrsa_pkg::CHANNEL_W'(k % NUM_CHANNELS));
                        if ($urandom_range(0, 4) == 0)
                            send_cmd(lrrsa_pkg::ACT_GRANT,
                                     lrrsa_pkg::PORT_W'($urandom_range(0, NUM_PORTS - 1)),
                                     3'd0, 2'd0);
                    end
            end
            else
            begin
                for (int j = 0; j < 64; j++)
                begin
                    r   = $urandom_range(0, 99);
                    op  = lrrsa_pkg::PORT_W'($urandom_range(0, NUM_PORTS - 1));
                    ip  = lrrsa_pkg::PORT_W'($urandom_range(0, NUM_PORTS - 1));
                    ich = lrrsa_pkg::CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1));
                    if (r < 6)
                    begin
                        act = lrrsa_pkg::ACTION_W'($urandom_range(0, 3));
                        op  = lrrsa_pkg::PORT_W'($urandom_range(0, 7));
                        ip  = lrrsa_pkg::PORT_W'($urandom_range(0, 7));
                        ich = lrrsa_pkg::CHANNEL_W'($urandom_range(0, 3));
                    end
                    else if (r < (fill ? 66 : 21))
                        act = lrrsa_pkg::ACT_SET;
                    else if (r < (fill ? 88 : 46))
                        act = lrrsa_pkg::ACT_GRANT;
                    else
                        act = lrrsa_pkg::ACT_CLEAR;
                    send_cmd(act, op, ip, ich);
                    if (sent >= STALL_AT)
                        stall_req = 1'b1;
                    if (sent >= RAND_ITEMS - QUIET_TAIL)
                        quiet = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lrrsa_pkg.sv
hw/rtl/lrrsa_ctrl.sv
hw/rtl/lrrsa_datapath.sv
hw/rtl/locking_round_robin_switch_allocator_core.sv
test/alloc_checker.sv
test/tb.sv
